### sv/olist_pkg.sv
package olist_pkg;

  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_RM_FRONT  = 3'd2,
    ACT_RM_BACK   = 3'd3,
    ACT_RM_AT     = 3'd4,
    ACT_RD_AT     = 3'd5,
    ACT_SEARCH    = 3'd6,
    ACT_NOP       = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic rd_en;
    logic val_wr;
    logic lnk_wr;
  } ram_cmd_t;

endpackage

### sv/olist_ram.sv
module olist_ram
  import olist_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int DW    = 32,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  ram_cmd_t      cmd,
  input  logic [AW-1:0] raddr,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wval,
  input  logic [AW-1:0] wlnk,
  output logic [DW-1:0] rval,
  output logic [AW-1:0] rlnk
);

  logic [DW-1:0] val_mem [DEPTH];
  logic [AW-1:0] lnk_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.val_wr) begin
      val_mem[waddr] <= wval;
    end
    if (cmd.lnk_wr) begin
      lnk_mem[waddr] <= wlnk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rval <= val_mem[raddr];
      rlnk <= lnk_mem[raddr];
    end
  end

endmodule

### sv/ordered_list_engine_unit.sv
// Bounded ordered list of signed values kept as linked slots in a slot RAM,
// with a last-freed-first free list. One request is worked at a time; in_stall
// is high while it runs. Remove-back, remove-at and read-at walk the links one
// slot per cycle through the single registered read port of the slot RAM; search
// walks the links the same way until it finds a match or reaches the last entry.
// The finished result waits in an output register, so the next request is taken
// while it is still stalled. No clearing pass is needed after reset.
module ordered_list_engine_unit
  import olist_pkg::*;
#(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         action,
  input  logic signed [31:0] value,
  input  logic [8:0]         position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [31:0] data_value,
  output logic [8:0]         found_position,
  output logic [8:0]         entry_count
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 9) ? CW : 9;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_EXEC   = 11'b000_0000_0010,
    S_TAKE   = 11'b000_0000_0100,
    S_INS    = 11'b000_0000_1000,
    S_LTAIL  = 11'b000_0001_0000,
    S_WALK   = 11'b000_0010_0000,
    S_RA1    = 11'b000_0100_0000,
    S_RA2    = 11'b000_1000_0000,
    S_SEARCH = 11'b001_0000_0000,
    S_DONE   = 11'b010_0000_0000,
    S_SPARE  = 11'b100_0000_0000
  } state_t;

  state_t state;

  action_t               req_act;
  logic [DATA_WIDTH-1:0] req_val;
  logic [8:0]            req_pos;
  logic [SW-1:0]         head;
  logic [SW-1:0]         tail;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         fresh;
  logic [SW-1:0]         free_head;
  logic [CW-1:0]         free_cnt;
  logic [SW-1:0]         slot;
  logic [SW-1:0]         cur;
  logic [CW-1:0]         rem;
  logic                  front_rm;
  status_t               res_status;
  logic [DATA_WIDTH-1:0] res_data;
  logic [8:0]            res_found;

  ram_cmd_t              cmd;
  logic [SW-1:0]         raddr;
  logic [SW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wval;
  logic [SW-1:0]         wlnk;
  logic [DATA_WIDTH-1:0] rd_val;
  logic [SW-1:0]         rd_lnk;

  logic [PW-1:0]         pos_w;
  logic                  pos_bad;
  logic                  is_full;
  logic                  out_free;
  logic signed [63:0]    data_ext;

  olist_ram #(
    .DEPTH(CAPACITY),
    .DW   (DATA_WIDTH),
    .AW   (SW)
  ) u_ram (
    .clk  (clk),
    .cmd  (cmd),
    .raddr(raddr),
    .waddr(waddr),
    .wval (wval),
    .wlnk (wlnk),
    .rval (rd_val),
    .rlnk (rd_lnk)
  );

  assign in_stall = (state != S_IDLE);
  assign pos_w    = PW'(req_pos);
  assign pos_bad  = (req_pos == 9'd0) || (pos_w > PW'(cnt));
  assign is_full  = (cnt == CW'(CAPACITY));
  assign out_free = !out_valid || !out_stall;
  assign data_ext = 64'($signed(res_data));

  always_comb begin
    cmd   = '0;
    raddr = head;
    waddr = slot;
    wval  = req_val;
    wlnk  = '0;
    unique case (state)
      S_EXEC: begin
        unique case (req_act)
          ACT_INS_FRONT, ACT_INS_BACK: begin
            raddr     = free_head;
            cmd.rd_en = !is_full && (free_cnt != '0);
          end
          ACT_RM_FRONT, ACT_RM_BACK: begin
            cmd.rd_en = (cnt != '0);
          end
          ACT_RM_AT, ACT_RD_AT: begin
            cmd.rd_en = (cnt != '0) && !pos_bad;
          end
          ACT_SEARCH: begin
            cmd.rd_en = (cnt != '0);
          end
          default: begin
          end
        endcase
      end
      S_INS: begin
        cmd.val_wr = 1'b1;
        cmd.lnk_wr = 1'b1;
        wlnk       = (cnt != '0 && req_act == ACT_INS_FRONT) ? head : '0;
      end
      S_LTAIL: begin
        cmd.lnk_wr = 1'b1;
        waddr      = tail;
        wlnk       = slot;
      end
      S_WALK: begin
        raddr = rd_lnk;
        if (rem == '0) begin
          if (req_act != ACT_RD_AT) begin
            if (front_rm) begin
              cmd.lnk_wr = 1'b1;
              waddr      = cur;
              wlnk       = free_head;
            end else begin
              cmd.rd_en = 1'b1;
            end
          end
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      S_RA1: begin
        cmd.lnk_wr = 1'b1;
        waddr      = cur;
        wlnk       = rd_lnk;
      end
      S_RA2: begin
        cmd.lnk_wr = 1'b1;
        waddr      = slot;
        wlnk       = free_head;
      end
      S_SEARCH: begin
        raddr     = rd_lnk;
        cmd.rd_en = (rd_val != req_val) && ((rem + CW'(1)) != cnt);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      cnt       <= '0;
      fresh     <= '0;
      free_head <= '0;
      free_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_act    <= action_t'(action);
            req_val    <= DATA_WIDTH'($unsigned(value));
            req_pos    <= position;
            res_status <= ST_OK;
            res_data   <= '0;
            res_found  <= '0;
            state      <= S_EXEC;
          end
        end
        S_EXEC: begin
          cur <= head;
          unique case (req_act)
            ACT_INS_FRONT, ACT_INS_BACK: begin
              if (is_full) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else if (free_cnt != '0) begin
                state <= S_TAKE;
              end else begin
                slot  <= fresh[SW-1:0];
                fresh <= fresh + CW'(1);
                state <= S_INS;
              end
            end
            ACT_RM_FRONT, ACT_RM_BACK, ACT_RM_AT, ACT_RD_AT: begin
              if (cnt == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else if ((req_act == ACT_RM_AT || req_act == ACT_RD_AT) && pos_bad) begin
                res_status <= ST_BAD_POS;
                state      <= S_DONE;
              end else begin
                state <= S_WALK;
                unique case (req_act)
                  ACT_RM_FRONT: begin
                    rem      <= '0;
                    front_rm <= 1'b1;
                  end
                  ACT_RM_BACK: begin
                    rem      <= (cnt == CW'(1)) ? '0 : CW'(cnt - CW'(2));
                    front_rm <= (cnt == CW'(1));
                  end
                  ACT_RM_AT: begin
                    rem      <= (req_pos == 9'd1) ? '0 : CW'(pos_w - PW'(2));
                    front_rm <= (req_pos == 9'd1);
                  end
                  default: begin
                    rem      <= CW'(pos_w - PW'(1));
                    front_rm <= 1'b0;
                  end
                endcase
              end
            end
            ACT_SEARCH: begin
              if (cnt == '0) begin
                res_status <= ST_NOT_FOUND;
                state      <= S_DONE;
              end else begin
                rem   <= '0;
                state <= S_SEARCH;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_TAKE: begin
          slot      <= free_head;
          free_head <= rd_lnk;
          free_cnt  <= free_cnt - CW'(1);
          state     <= S_INS;
        end
        S_INS: begin
          cnt <= cnt + CW'(1);
          if (cnt == '0) begin
            head  <= slot;
            tail  <= slot;
            state <= S_DONE;
          end else if (req_act == ACT_INS_FRONT) begin
            head  <= slot;
            state <= S_DONE;
          end else begin
            state <= S_LTAIL;
          end
        end
        S_LTAIL: begin
          tail  <= slot;
          state <= S_DONE;
        end
        S_WALK: begin
          if (rem == '0) begin
            if (req_act == ACT_RD_AT) begin
              res_data <= rd_val;
              state    <= S_DONE;
            end else if (front_rm) begin
              res_data  <= rd_val;
              free_head <= cur;
              free_cnt  <= free_cnt + CW'(1);
              cnt       <= cnt - CW'(1);
              if (cnt == CW'(1)) begin
                head <= '0;
                tail <= '0;
              end else begin
                head <= rd_lnk;
              end
              state <= S_DONE;
            end else begin
              slot  <= rd_lnk;
              state <= S_RA1;
            end
          end else begin
            cur <= rd_lnk;
            rem <= rem - CW'(1);
          end
        end
        S_RA1: begin
          res_data <= rd_val;
          if (slot == tail) begin
            tail <= cur;
          end
          state <= S_RA2;
        end
        S_RA2: begin
          free_head <= slot;
          free_cnt  <= free_cnt + CW'(1);
          cnt       <= cnt - CW'(1);
          state     <= S_DONE;
        end
        S_SEARCH: begin
          if (rd_val == req_val) begin
            res_data  <= req_val;
            res_found <= 9'(rem + CW'(1));
            state     <= S_DONE;
          end else if ((rem + CW'(1)) == cnt) begin
            res_status <= ST_NOT_FOUND;
            state      <= S_DONE;
          end else begin
            rem <= rem + CW'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            status         <= res_status;
            data_value     <= data_ext[31:0];
            found_position <= res_found;
            entry_count    <= 9'(cnt);
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (cnt <= CW'(CAPACITY)))
    else $error("entry count above capacity");

  a_slot_balance: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |->
      (({1'b0, cnt} + {1'b0, free_cnt}) == {1'b0, fresh}))
    else $error("slot accounting lost a slot");

  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cnt == '0) |-> (head == '0 && tail == '0))
    else $error("empty list with stale head or tail");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished result not loaded");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result without finished request");
`endif

endmodule
